// ===== design/arc_length_inverse_lookup_unit_defines.svh =====
// Assertion helpers shared by the arc length lookup modules.
// Both expect clk_i and rst_ni in scope.
`ifndef ARC_LENGTH_INVERSE_LOOKUP_UNIT_DEFINES_SVH
`define ARC_LENGTH_INVERSE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ALIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/alil_pkg.sv =====
package alil_pkg;

  localparam int TABLE_POINTS_DEF = 256;
  // Divider numerator width: covers s*(n-2) and a 32-bit remainder times 2^16.
  localparam int DIV_W = 48;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  typedef enum logic [1:0] {
    RA_LAST,
    RA_ZERO,
    RA_IDX,
    RA_IDX1
  } ra_sel_e;

  typedef enum logic [1:0] {
    RES_RD,
    RES_PI,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic              mode;
    logic [7:0]        entry_index;
    logic signed [31:0] arc_length;
    logic signed [31:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] param_out;
    logic [1:0]         query_status;
  } out_item_t;

  typedef struct packed {
    logic       load_we;
    logic       take_query;
    ra_sel_e    ra_sel;
    logic       chk_prod;
    logic       idx_clr;
    logic       div_start;
    logic       div_frac;
    logic       idx_from_div;
    logic       idx_dec;
    logic       idx_inc;
    logic       idx_clamp;
    logic       lat_i;
    logic       lat_j;
    logic       f_zero;
    logic       f_one;
    logic       f_div;
    logic       mul_f;
    logic       out_load;
    res_sel_e   res_sel;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic s_neg;
    logic s_gt_len;
    logic len_zero;
    logic idx_gt0;
    logic rd_gt_s;
    logic rd_lt_s;
    logic idx1_lt_n;
    logic den_le0;
    logic num_le0;
    logic num_ge_den;
    logic div_done;
  } sts_t;

endpackage

// ===== design/alil_div.sv =====
module alil_div import alil_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] numer_i,
  input  logic [31:0]      denom_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [32:0]      rem_q, rem_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [31:0]      den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [32:0]      sh;
  logic             ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    sh    = {rem_q[31:0], num_q[DIV_W-1]};
    ge    = (sh >= {1'b0, den_q});
    rem_d = ge ? (sh - {1'b0, den_q}) : sh;
    num_d = {num_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      num_q <= numer_i;
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== design/alil_datapath.sv =====
module alil_datapath import alil_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic [8:0] cfg_data_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output out_item_t  out_data_o
);

  `include "arc_length_inverse_lookup_unit_defines.svh"

  localparam int IW = $clog2(TABLE_POINTS);
  localparam int NW = $clog2(TABLE_POINTS + 1);

  logic signed [31:0] len_mem [TABLE_POINTS];
  logic signed [31:0] par_mem [TABLE_POINTS];

  logic [8:0]         points_q;
  logic [NW-1:0]      n_sat, n_q;
  logic signed [31:0] s_q;
  logic [NW-1:0]      idx_q, idx1, nm2;
  logic [NW-1:0]      rd_addr;
  logic signed [31:0] rd_l_q, rd_p_q;
  logic signed [31:0] li_q, pi_q, lj_q, pj_q;
  logic [DIV_W-1:0]   prod_q;
  logic [16:0]        f_q;
  logic signed [50:0] prod2_q;
  logic signed [32:0] den, num, dp;
  logic signed [35:0] interp;
  logic signed [31:0] interp_sat;
  logic [DIV_W-1:0]   div_num, quot;
  logic [31:0]        div_den;
  logic               div_busy, div_done;
  logic signed [31:0] res;
  out_item_t          out_q;

  // Point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= 9'd2;
    end else if (cfg_valid_i) begin
      points_q <= cfg_data_i;
    end
  end

  // Clamp the point count to the range 2 to the table size
  always_comb begin
    if (points_q < 9'd2) begin
      n_sat = NW'(2);
    end else if (32'(points_q) > 32'(TABLE_POINTS)) begin
      n_sat = NW'(TABLE_POINTS);
    end else begin
      n_sat = NW'(points_q);
    end
  end

  assign idx1 = idx_q + 1'b1;
  assign nm2  = n_q - NW'(2);

  // Table read address
  always_comb begin
    case (cmd_i.ra_sel)
      RA_LAST: rd_addr = n_q - 1'b1;
      RA_ZERO: rd_addr = '0;
      RA_IDX:  rd_addr = idx_q;
      RA_IDX1: rd_addr = idx1;
      default: rd_addr = idx_q;
    endcase
  end

  // Table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (32'(in_data_i.entry_index) < 32'(TABLE_POINTS))) begin
      len_mem[IW'(in_data_i.entry_index)] <= in_data_i.arc_length;
      par_mem[IW'(in_data_i.entry_index)] <= in_data_i.param_value;
    end
    rd_l_q <= len_mem[rd_addr[IW-1:0]];
    rd_p_q <= par_mem[rd_addr[IW-1:0]];
  end

  // Shared divider: start index estimate or interpolation fraction
  assign div_num = cmd_i.div_frac ? {num[31:0], 16'd0} : prod_q;
  assign div_den = cmd_i.div_frac ? den[31:0] : rd_l_q;

  alil_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (div_num),
    .denom_i (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Interval width, offset and parameter step
  assign den = 33'(lj_q) - 33'(li_q);
  assign num = 33'(s_q) - 33'(li_q);
  assign dp  = 33'(pj_q) - 33'(pi_q);

  // Query registers and walk index
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_query) begin
      s_q <= in_data_i.arc_length;
      n_q <= n_sat;
    end
    if (cmd_i.chk_prod) begin
      prod_q <= DIV_W'(s_q[30:0] * nm2);
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_from_div) begin
      idx_q <= (quot > DIV_W'(nm2)) ? nm2 : NW'(quot);
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - 1'b1;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx1;
    end else if (cmd_i.idx_clamp && (idx_q > nm2)) begin
      idx_q <= nm2;
    end
    if (cmd_i.lat_i) begin
      li_q <= rd_l_q;
      pi_q <= rd_p_q;
    end
    if (cmd_i.lat_j) begin
      lj_q <= rd_l_q;
      pj_q <= rd_p_q;
    end
    if (cmd_i.f_zero) begin
      f_q <= '0;
    end else if (cmd_i.f_one) begin
      f_q <= 17'h10000;
    end else if (cmd_i.f_div) begin
      f_q <= {1'b0, quot[15:0]};
    end
    if (cmd_i.mul_f) begin
      prod2_q <= $signed({1'b0, f_q}) * dp;
    end
  end

  // Add the floored step and saturate to 32 bits
  always_comb begin
    interp = 36'(pi_q) + 36'(prod2_q >>> 16);
    if (interp > 36'sd2147483647) begin
      interp_sat = 32'sh7fffffff;
    end else if (interp < -36'sd2147483648) begin
      interp_sat = 32'sh80000000;
    end else begin
      interp_sat = interp[31:0];
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_RD:     res = rd_p_q;
      RES_PI:     res = pi_q;
      RES_INTERP: res = interp_sat;
      default:    res = interp_sat;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.param_out    <= res;
      out_q.query_status <= cmd_i.status;
    end
  end

  assign out_data_o = out_q;

  // Status to the controller
  always_comb begin
    sts_o.mode       = in_data_i.mode;
    sts_o.s_neg      = s_q[31];
    sts_o.s_gt_len   = (s_q > rd_l_q);
    sts_o.len_zero   = (rd_l_q == 32'sd0);
    sts_o.idx_gt0    = (idx_q != '0);
    sts_o.rd_gt_s    = (rd_l_q > s_q);
    sts_o.rd_lt_s    = (rd_l_q < s_q);
    sts_o.idx1_lt_n  = (idx1 < n_q);
    sts_o.den_le0    = (den <= 33'sd0);
    sts_o.num_le0    = (num <= 33'sd0);
    sts_o.num_ge_den = (num >= den);
    sts_o.div_done   = div_done;
  end

  `ALIL_ASSERT_NOW(a_div_start_idle, cmd_i.div_start, !div_busy, "divider restarted while busy")
  `ALIL_ASSERT_NEXT(a_div_runs, cmd_i.div_start, div_busy, "divider did not start")
  `ALIL_ASSERT_NOW(a_clamped_idx, cmd_i.lat_i, idx_q <= nm2, "interval index beyond n-2")

endmodule

// ===== design/alil_ctrl.sv =====
module alil_ctrl import alil_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  `include "arc_length_inverse_lookup_unit_defines.svh"

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RD_LAST  = 5'd1;
  localparam logic [4:0] S_CHK      = 5'd2;
  localparam logic [4:0] S_RD_ZERO  = 5'd3;
  localparam logic [4:0] S_ZERO_W   = 5'd4;
  localparam logic [4:0] S_MULI     = 5'd5;
  localparam logic [4:0] S_DIV_IDX  = 5'd6;
  localparam logic [4:0] S_DOWN_RD  = 5'd7;
  localparam logic [4:0] S_DOWN_CMP = 5'd8;
  localparam logic [4:0] S_UP_RD    = 5'd9;
  localparam logic [4:0] S_UP_CMP   = 5'd10;
  localparam logic [4:0] S_CLAMP    = 5'd11;
  localparam logic [4:0] S_RDI      = 5'd12;
  localparam logic [4:0] S_RDI_W    = 5'd13;
  localparam logic [4:0] S_RDJ_W    = 5'd14;
  localparam logic [4:0] S_EVAL     = 5'd15;
  localparam logic [4:0] S_DIV_F    = 5'd16;
  localparam logic [4:0] S_MUL_F    = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ra_sel  = RA_IDX;
    cmd_o.res_sel = RES_INTERP;
    cmd_o.status  = ST_INTERP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.mode) begin
            cmd_o.take_query = 1'b1;
            state_d = S_RD_LAST;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      S_RD_LAST: begin
        cmd_o.ra_sel = RA_LAST;
        state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.ra_sel   = RA_LAST;
        cmd_o.chk_prod = 1'b1;
        if (sts_i.s_neg) begin
          state_d = S_RD_ZERO;
        end else if (sts_i.s_gt_len) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_RD;
            cmd_o.status   = ST_BEYOND;
            state_d = S_IDLE;
          end
        end else if (sts_i.len_zero) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_DOWN_RD;
        end else begin
          state_d = S_MULI;
        end
      end
      S_RD_ZERO: begin
        cmd_o.ra_sel = RA_ZERO;
        state_d = S_ZERO_W;
      end
      S_ZERO_W: begin
        cmd_o.ra_sel = RA_ZERO;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_RD;
          cmd_o.status   = ST_BELOW;
          state_d = S_IDLE;
        end
      end
      S_MULI: begin
        cmd_o.ra_sel    = RA_LAST;
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_IDX;
      end
      S_DIV_IDX: begin
        if (sts_i.div_done) begin
          cmd_o.idx_from_div = 1'b1;
          state_d = S_DOWN_RD;
        end
      end
      S_DOWN_RD: begin
        state_d = S_DOWN_CMP;
      end
      S_DOWN_CMP: begin
        if (sts_i.idx_gt0 && sts_i.rd_gt_s) begin
          cmd_o.idx_dec = 1'b1;
          state_d = S_DOWN_RD;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd_o.ra_sel = RA_IDX1;
        state_d = sts_i.idx1_lt_n ? S_UP_CMP : S_CLAMP;
      end
      S_UP_CMP: begin
        if (sts_i.rd_lt_s) begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_UP_RD;
        end else begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd_o.idx_clamp = 1'b1;
        state_d = S_RDI;
      end
      S_RDI: begin
        state_d = S_RDI_W;
      end
      S_RDI_W: begin
        cmd_o.lat_i  = 1'b1;
        cmd_o.ra_sel = RA_IDX1;
        state_d = S_RDJ_W;
      end
      S_RDJ_W: begin
        cmd_o.lat_j = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.den_le0) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.res_sel  = RES_PI;
            state_d = S_IDLE;
          end
        end else if (sts_i.num_le0) begin
          cmd_o.f_zero = 1'b1;
          state_d = S_MUL_F;
        end else if (sts_i.num_ge_den) begin
          cmd_o.f_one = 1'b1;
          state_d = S_MUL_F;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_frac  = 1'b1;
          state_d = S_DIV_F;
        end
      end
      S_DIV_F: begin
        if (sts_i.div_done) begin
          cmd_o.f_div = 1'b1;
          state_d = S_MUL_F;
        end
      end
      S_MUL_F: begin
        cmd_o.mul_f = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, drop when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `ALIL_ASSERT_NOW(a_out_free, cmd_o.out_load, !out_valid_q || !out_stall_i, "result overwritten")
  `ALIL_ASSERT_NEXT(a_query_start, (state_q == S_IDLE) && in_valid_i && sts_i.mode, state_q == S_RD_LAST, "query not started")
  `ALIL_ASSERT_NOW(a_div_done_state, sts_i.div_done, (state_q == S_DIV_IDX) || (state_q == S_DIV_F), "divider result unexpected")

endmodule

// ===== design/arc_length_inverse_lookup_unit.sv =====
// Arc length to curve parameter lookup by piecewise linear interpolation.
// Input channel (in_valid_i / in_stall_o) carries load and query transactions;
// a load writes one length/parameter entry and gives no result, a query
// returns one result on the output channel (out_valid_o / out_stall_i).
// cfg_valid_i / cfg_ready_o writes the point count; ready is always high.
// Loads are written while the controller stays idle. A query beyond the end
// reads the last entry and loads its parameter from S_CHK, one below the start
// reads entry zero and loads it from S_ZERO_W. Otherwise s*(n-2) over the
// total length (skipped when that is zero) gives a start index, a walk down
// and up reads and compares one entry per step, and the interval is read; a
// flat or inverted one returns its lower parameter, a fraction of 0 or 1 needs
// no fraction division. The shared 48-step restoring divider does both divisions;
// the table has one read port. One query is in flight at a time; loads are
// taken while a result waits. Reset clears the controller and sets the point
// count to 2; table contents stay undefined until loaded. A stalled result
// holds in the output register; the next query does its work, then waits.
module arc_length_inverse_lookup_unit import alil_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  alil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  alil_datapath #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import alil_pkg::*;

  localparam int NPTS = 256;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [8:0] cfg_data_i;

  // table mirror and point count
  logic signed [31:0] len_tab [NPTS];
  logic signed [31:0] par_tab [NPTS];
  logic [8:0]         point_count;

  out_item_t expected_q[$];
  int        n_fail;
  int        n_results;
  int        n_queries;
  int        n_loads;
  bit        out_stall_on;

  arc_length_inverse_lookup_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic signed [63:0] floor_q16(logic signed [63:0] x);
    logic signed [63:0] r;
    r = x >>> 16;
    return r;
  endfunction

  // compute expected parameter for arc length s
  function automatic out_item_t param_for_length(logic signed [31:0] s);
    out_item_t r;
    logic signed [63:0] n, lenv, idx, den, num, f, dp, v, sx;
    sx = s;
    n = point_count;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    r.query_status = ST_INTERP;
    if (sx < 0) begin
      r.param_out = par_tab[0];
      r.query_status = ST_BELOW;
      return r;
    end
    if (sx > len_tab[n-1]) begin
      r.param_out = par_tab[n-1];
      r.query_status = ST_BEYOND;
      return r;
    end
    lenv = len_tab[n-1];
    idx = 0;
    if (lenv > 0) idx = (sx * (n - 2)) / lenv;
    if (idx < 0) idx = 0;
    if (idx > n - 2) idx = n - 2;
    while (idx > 0 && len_tab[idx] > sx) idx--;
    while (idx + 1 < n && len_tab[idx+1] < sx) idx++;
    if (idx > n - 2) idx = n - 2;
    den = len_tab[idx+1] - len_tab[idx];
    if (den <= 0) begin
      r.param_out = par_tab[idx];
      return r;
    end
    num = sx - len_tab[idx];
    if (num <= 0) f = 0;
    else if (num >= den) f = 65536;
    else f = (num * 65536) / den;
    dp = par_tab[idx+1] - par_tab[idx];
    v = par_tab[idx] + floor_q16(f * dp);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.param_out = v[31:0];
    return r;
  endfunction

  // check each accepted result
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: param_out %h", out_data_o.param_out);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.param_out !== e.param_out) begin
          $error("param_out expected %h actual %h", e.param_out, out_data_o.param_out);
          n_fail++;
        end
        if (out_data_o.query_status !== e.query_status) begin
          $error("query_status expected %0d actual %0d", e.query_status,
                 out_data_o.query_status);
          n_fail++;
        end
      end
    end
  end

  // randomize receiver stall
  always @(posedge clk_i) begin
    int r;
    if (!rst_ni || !out_stall_on) begin
      out_stall_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) out_stall_i <= 1'b1;
      else if (r < 40) out_stall_i <= ($urandom_range(0, 3) == 0);
      else if (!out_stall_i || r < 70) out_stall_i <= 1'b0;
    end
  end

  // drop valid for a random number of cycles, often none
  task automatic idle_gap();
    int r;
    int cycles;
    r = $urandom_range(0, 99);
    if (r < 50) cycles = 0;
    else if (r < 95) cycles = $urandom_range(1, 4);
    else cycles = $urandom_range(20, 150);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // send one transaction and record what it should produce
  task automatic send_item(logic mode, logic [7:0] ei, logic signed [31:0] s,
                           logic signed [31:0] p, bit gap);
    if (gap) idle_gap();
    in_data_i.mode <= mode;
    in_data_i.entry_index <= ei;
    in_data_i.arc_length <= s;
    in_data_i.param_value <= p;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mode == 1'b0) begin
      len_tab[ei] = s;
      par_tab[ei] = p;
      n_loads++;
    end else begin
      expected_q = {expected_q, param_for_length(s)};
      n_queries++;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_points(logic [8:0] v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    point_count = v;
    @(posedge clk_i);
  endtask

  // load n entries, monotone with random steps (some zero width)
  task automatic load_table(int n, int max_step, bit gap);
    logic signed [63:0] acc;
    int k;
    acc = 0;
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        if ($urandom_range(0, 9) == 0) acc = acc;
        else acc = acc + $urandom_range(1, max_step);
      end
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      send_item(1'b0, k[7:0], acc[31:0], $urandom(), gap);
    end
  endtask

  function automatic logic signed [31:0] pick_query(int n);
    logic signed [31:0] lenv;
    int r;
    lenv = len_tab[n-1];
    r = $urandom_range(0, 99);
    if (r < 8) return -32'($urandom_range(1, 1000));
    if (r < 10) return 32'sh8000_0000;
    if (r < 16) return (lenv == 32'sh7fff_ffff) ? lenv : lenv + $urandom_range(1, 5000);
    if (r < 18) return 32'sh7fff_ffff;
    if (r < 28) return len_tab[$urandom_range(0, n-1)];
    if (lenv <= 0) return 0;
    return $urandom_range(0, lenv);
  endfunction

  task automatic test_directed();
    int k;
    write_points(9'd2);
    send_item(1'b0, 8'd0, 32'sd0, 32'sh8000_0000, 1'b0);
    send_item(1'b0, 8'd1, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_item(1'b1, 8'hff, 32'sd0, 32'sd0, 1'b0);
    send_item(1'b1, 8'h00, 32'sh7fff_ffff, 32'sd0, 1'b0);
    send_item(1'b1, 8'h5a, 32'sh4000_0000, 32'sd0, 1'b0);
    send_item(1'b1, 8'h00, 32'sh8000_0000, 32'sd0, 1'b0);
    send_item(1'b1, 8'h00, -32'sd1, 32'sd0, 1'b0);
    // zero total length: all entries zero
    send_item(1'b0, 8'd1, 32'sd0, 32'sd77, 1'b0);
    send_item(1'b1, 8'h00, 32'sd0, 32'sd0, 1'b0);
    // inverted interval and entry out of order
    write_points(9'd3);
    send_item(1'b0, 8'd0, 32'sd100, 32'sd5, 1'b0);
    send_item(1'b0, 8'd1, 32'sd50, 32'sd9, 1'b0);
    send_item(1'b0, 8'd2, 32'sd200, -32'sd40, 1'b0);
    for (k = 0; k < 4; k++) send_item(1'b1, 8'h00, k * 60, 32'sd0, 1'b0);
    send_item(1'b1, 8'h00, 32'sd201, 32'sd0, 1'b0);
    // top entry index, extreme parameters
    send_item(1'b0, 8'd255, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
  endtask

  task automatic test_random_tables();
    int ph, k, n, cnt;
    int sizes[6] = '{256, 2, 3, 17, 64, 5};
    for (ph = 0; ph < 6; ph++) begin
      n = sizes[ph];
      write_points(n[8:0]);
      load_table(n, (ph == 0) ? 8000000 : 300000 + ph * 2000000, 1'b1);
      cnt = (n == 256) ? 150 : 200;
      for (k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(1'b0, 8'($urandom_range(0, n-1)), $urandom(), $urandom(), 1'b1);
        else
          send_item(1'b1, 8'($urandom()), pick_query(n), $urandom(), 1'b1);
        if (k == cnt / 2 && ph == 2) drain();
      end
    end
  endtask

  task automatic test_no_gaps();
    int k;
    write_points(9'd9);
    load_table(9, 50000, 1'b0);
    for (k = 0; k < 120; k++) send_item(1'b1, 8'($urandom()), pick_query(9), $urandom(), 1'b0);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    point_count = 9'd2;
    out_stall_on = 1'b0;
    n_fail = 0;
    n_results = 0;
    n_queries = 0;
    n_loads = 0;
    for (int k = 0; k < NPTS; k++) begin
      len_tab[k] = '0;
      par_tab[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    out_stall_on = 1'b1;
    test_random_tables();
    out_stall_on = 1'b0;
    test_no_gaps();
    out_stall_on = 1'b1;
    drain();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_fail++;
    end
    $display("Covered %0d loads and %0d queries, %0d results checked,", n_loads,
             n_queries, n_results);
    $display("tables of 2 to 256 points with clamps, flat and inverted intervals.");
    if (n_fail == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== arc_length_inverse_lookup_unit.f =====
+incdir+design
design/alil_pkg.sv
design/alil_div.sv
design/alil_datapath.sv
design/alil_ctrl.sv
design/arc_length_inverse_lookup_unit.sv
bench/tb.sv
